### src/lpcc_pkg.sv
// Shared types, constants and configuration register indexes of the lidar
// point colorizer. Used by every module of the block; depends on nothing.
package lpcc_pkg;

  // Default frame store geometry.
  localparam int MaxWidthDef  = 2048;
  localparam int MaxHeightDef = 2048;

  // Fixed calibration: focal term 935.307436 in Q.16, depth offset 0.3 and
  // camera x offset 1.5, both in Q16.16.
  localparam logic signed [26:0] CoefF    = 27'sd61296308;
  localparam logic signed [32:0] DepthOfs = 33'sd19661;
  localparam logic signed [32:0] CamxOfs  = 33'sd98304;

  // Internal widths.
  localparam int CamW = 33;  // camera coordinates
  localparam int KuW  = 60;  // focal product
  localparam int CuW  = 44;  // principal point term before the 2^16 scale
  localparam int NumW = 61;  // projection numerators
  localparam int CzW  = 31;  // positive depth
  localparam int AccW = 56;  // pose accumulator

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 63;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROT_ROW0     = 3'd0,
    CFG_ROT_ROW1     = 3'd1,
    CFG_ROT_ROW2     = 3'd2,
    CFG_SHIFT_X      = 3'd3,
    CFG_SHIFT_Y      = 3'd4,
    CFG_SHIFT_Z      = 3'd5,
    CFG_IMAGE_WIDTH  = 3'd6,
    CFG_IMAGE_HEIGHT = 3'd7
  } cfg_idx_e;

  // Reset values of the configuration registers (identity pose, full HD).
  localparam logic [62:0] RotRow0Rst = 63'd262144;
  localparam logic [62:0] RotRow1Rst = 63'd549755813888;
  localparam logic [62:0] RotRow2Rst = 63'd1152921504606846976;
  localparam logic [11:0] WidthRst   = 12'd1920;
  localparam logic [11:0] HeightRst  = 12'd1080;

  // Input item: a pixel write (mode 0) or a lidar point (mode 1).
  typedef struct packed {
    logic               mode;
    logic [10:0]        pixel_col;
    logic [10:0]        pixel_row;
    logic [7:0]         pixel_red;
    logic [7:0]         pixel_green;
    logic [7:0]         pixel_blue;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_t;

  // Result item: transformed position and sampled color.
  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [7:0]         color_red;
    logic [7:0]         color_green;
    logic [7:0]         color_blue;
  } out_t;

  // Data that rides along the projection and division stages.
  typedef struct packed {
    logic               mode;
    logic               wr_ok;
    logic [23:0]        wr_rgb;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } side_t;

endpackage

### src/lpcc_front.sv
// Front end of the colorizer pipeline: camera coordinates, projection
// numerators and pose transform over three register stages. Uses lpcc_pkg.
module lpcc_front #(
  parameter int MAX_WIDTH  = lpcc_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = lpcc_pkg::MaxHeightDef,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                             clk_i,
  input  logic [2:0]                       en_i,
  input  lpcc_pkg::in_t                    in_i,
  input  logic [2:0][62:0]                 rot_i,
  input  logic [2:0][31:0]                 shift_i,
  output logic signed [lpcc_pkg::NumW-1:0] nu_o,
  output logic signed [lpcc_pkg::NumW-1:0] nv_o,
  output logic [lpcc_pkg::CzW-1:0]         cz_o,
  output logic                             drop_o,
  output lpcc_pkg::side_t                  side_o,
  output logic [AW-1:0]                    waddr_o
);

  localparam logic signed [lpcc_pkg::AccW-1:0] RoundHalf = 56'sd131072;
  localparam logic signed [lpcc_pkg::AccW-1:0] SatHi     = 56'sh00_0000_7FFF_FFFF;
  localparam logic signed [lpcc_pkg::AccW-1:0] SatLo     = 56'shFF_FFFF_8000_0000;

  // Stage 1 registers.
  logic signed [lpcc_pkg::CamW-1:0] cx1_q, cy1_q, cz1_q;
  logic                             drop1_q, mode1_q, wok1_q;
  logic [23:0]                      rgb1_q;
  logic [AW-1:0]                    waddr1_q;
  logic signed [52:0]               prod_q [3][3];

  // Stage 2 registers.
  logic signed [lpcc_pkg::KuW-1:0]  ku2_q, kv2_q;
  logic signed [lpcc_pkg::CuW-1:0]  cu2_q, cv2_q;
  logic signed [lpcc_pkg::CamW-1:0] cz2_q;
  logic                             drop2_q, mode2_q, wok2_q;
  logic [23:0]                      rgb2_q;
  logic [AW-1:0]                    waddr2_q;
  logic signed [lpcc_pkg::AccW-1:0] acc2_q [3];

  // Stage 3 registers.
  logic signed [lpcc_pkg::NumW-1:0] nu3_q, nv3_q;
  logic [lpcc_pkg::CzW-1:0]         cz3_q;
  logic                             drop3_q;
  lpcc_pkg::side_t                  side3_q;
  logic [AW-1:0]                    waddr3_q;

  // Stage 1 logic: camera frame, rejection tests, pose products, write address.
  logic signed [lpcc_pkg::CamW-1:0] cx_d, cy_d, cz_d;
  logic                             wok_d;
  logic [AW-1:0]                    waddr_d;
  logic signed [31:0]               pv [3];
  logic signed [20:0]               ent [3][3];
  logic signed [52:0]               prod_d [3][3];

  always_comb begin
    pv[0] = in_i.point_x;
    pv[1] = in_i.point_y;
    pv[2] = in_i.point_z;
    cx_d  = lpcc_pkg::CamxOfs - lpcc_pkg::CamW'(in_i.point_y);
    cy_d  = -lpcc_pkg::CamW'(in_i.point_z);
    cz_d  = lpcc_pkg::CamW'(in_i.point_x) - lpcc_pkg::DepthOfs;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        ent[r][k]    = rot_i[r][21*k +: 21];
        prod_d[r][k] = ent[r][k] * pv[k];
      end
    end
    wok_d   = (int'(in_i.pixel_col) < MAX_WIDTH) && (int'(in_i.pixel_row) < MAX_HEIGHT);
    waddr_d = AW'(in_i.pixel_row) * AW'(MAX_WIDTH) + AW'(in_i.pixel_col);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cx1_q    <= cx_d;
      cy1_q    <= cy_d;
      cz1_q    <= cz_d;
      drop1_q  <= in_i.point_x[31] || (cz_d <= 0);
      mode1_q  <= in_i.mode;
      wok1_q   <= wok_d;
      rgb1_q   <= {in_i.pixel_red, in_i.pixel_green, in_i.pixel_blue};
      waddr1_q <= waddr_d;
      prod_q   <= prod_d;
    end
  end

  // Stage 2 logic: focal products, principal point terms, pose sums.
  logic signed [lpcc_pkg::CuW-1:0]  czw;
  logic signed [lpcc_pkg::AccW-1:0] acc_d [3];

  always_comb begin
    czw = lpcc_pkg::CuW'(cz1_q);
    for (int r = 0; r < 3; r++) begin
      acc_d[r] = lpcc_pkg::AccW'(prod_q[r][0]) + lpcc_pkg::AccW'(prod_q[r][1])
               + lpcc_pkg::AccW'(prod_q[r][2])
               + (lpcc_pkg::AccW'($signed(shift_i[r])) <<< 18) + RoundHalf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ku2_q    <= lpcc_pkg::CoefF * cx1_q;
      kv2_q    <= lpcc_pkg::CoefF * cy1_q;
      // 960 = 1024 - 64 and 540 = 512 + 16 + 8 + 4.
      cu2_q    <= (czw <<< 10) - (czw <<< 6);
      cv2_q    <= (czw <<< 9) + (czw <<< 4) + (czw <<< 3) + (czw <<< 2);
      cz2_q    <= cz1_q;
      drop2_q  <= drop1_q;
      mode2_q  <= mode1_q;
      wok2_q   <= wok1_q;
      rgb2_q   <= rgb1_q;
      waddr2_q <= waddr1_q;
      acc2_q   <= acc_d;
    end
  end

  // Stage 3 logic: numerators and rounded, saturated pose results.
  logic signed [lpcc_pkg::AccW-1:0] shr [3];
  logic signed [31:0]               world [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shr[r] = acc2_q[r] >>> 18;
      if (shr[r] > SatHi) begin
        world[r] = 32'sh7FFF_FFFF;
      end else if (shr[r] < SatLo) begin
        world[r] = 32'sh8000_0000;
      end else begin
        world[r] = shr[r][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      nu3_q           <= lpcc_pkg::NumW'(ku2_q) + (lpcc_pkg::NumW'(cu2_q) <<< 16);
      nv3_q           <= lpcc_pkg::NumW'(kv2_q) + (lpcc_pkg::NumW'(cv2_q) <<< 16);
      cz3_q           <= cz2_q[lpcc_pkg::CzW-1:0];
      drop3_q         <= drop2_q;
      side3_q.mode    <= mode2_q;
      side3_q.wr_ok   <= wok2_q;
      side3_q.wr_rgb  <= rgb2_q;
      side3_q.world_x <= world[0];
      side3_q.world_y <= world[1];
      side3_q.world_z <= world[2];
      waddr3_q        <= waddr2_q;
    end
  end

  assign nu_o    = nu3_q;
  assign nv_o    = nv3_q;
  assign cz_o    = cz3_q;
  assign drop_o  = drop3_q;
  assign side_o  = side3_q;
  assign waddr_o = waddr3_q;

endmodule

### src/lpcc_div.sv
// Range check and pipelined restoring division that turn the projection
// numerators into a pixel address, one quotient bit per stage. Uses lpcc_pkg.
module lpcc_div #(
  parameter int MAX_WIDTH  = lpcc_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = lpcc_pkg::MaxHeightDef,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT),
  parameter int UW         = $clog2(MAX_WIDTH),
  parameter int VW         = $clog2(MAX_HEIGHT),
  parameter int DW         = (UW > VW) ? UW : VW
) (
  input  logic                             clk_i,
  input  logic [DW+1:0]                    en_i,
  input  logic signed [lpcc_pkg::NumW-1:0] nu_i,
  input  logic signed [lpcc_pkg::NumW-1:0] nv_i,
  input  logic [lpcc_pkg::CzW-1:0]         cz_i,
  input  logic                             drop_i,
  input  lpcc_pkg::side_t                  side_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic [11:0]                      image_width_i,
  input  logic [11:0]                      image_height_i,
  output logic [AW-1:0]                    addr_o,
  output logic                             hit_o,
  output lpcc_pkg::side_t                  side_o
);

  localparam int NW   = lpcc_pkg::NumW;
  localparam int RW   = NW - 1;
  localparam int DenW = lpcc_pkg::CzW + 16;

  // Per-stage registers; index 0 is the range check stage.
  logic [RW-1:0]   rem_u_q [DW+1];
  logic [RW-1:0]   rem_v_q [DW+1];
  logic [DW-1:0]   quo_u_q [DW+1];
  logic [DW-1:0]   quo_v_q [DW+1];
  logic [DenW-1:0] den_q   [DW+1];
  logic            ok_q    [DW+1];
  lpcc_pkg::side_t side_q  [DW+1];
  logic [AW-1:0]   waddr_q [DW+1];

  // Range check: a quotient truncated toward zero lands in [0, 2^UW) exactly
  // when the numerator lies in (-den, den * 2^UW).
  logic signed [NW-1:0] den_s;
  logic                 uok, vok;

  assign den_s = $signed(NW'({cz_i, 16'b0}));
  assign uok   = (nu_i > -den_s) && (nu_i < (den_s <<< UW));
  assign vok   = (nv_i > -den_s) && (nv_i < (den_s <<< VW));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_u_q[0] <= nu_i[NW-1] ? '0 : nu_i[RW-1:0];
      rem_v_q[0] <= nv_i[NW-1] ? '0 : nv_i[RW-1:0];
      quo_u_q[0] <= '0;
      quo_v_q[0] <= '0;
      den_q[0]   <= {cz_i, 16'b0};
      ok_q[0]    <= !drop_i && uok && vok;
      side_q[0]  <= side_i;
      waddr_q[0] <= waddr_i;
    end
  end

  // Division stages, most significant quotient bit first.
  for (genvar j = 1; j <= DW; j++) begin : g_div
    logic [RW-1:0] dsh;
    logic [RW:0]   tu, tv;

    assign dsh = RW'(den_q[j-1]) << (DW - j);
    assign tu  = {1'b0, rem_u_q[j-1]} - {1'b0, dsh};
    assign tv  = {1'b0, rem_v_q[j-1]} - {1'b0, dsh};

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_u_q[j] <= tu[RW] ? rem_u_q[j-1] : tu[RW-1:0];
        rem_v_q[j] <= tv[RW] ? rem_v_q[j-1] : tv[RW-1:0];
        quo_u_q[j] <= {quo_u_q[j-1][DW-2:0], !tu[RW]};
        quo_v_q[j] <= {quo_v_q[j-1][DW-2:0], !tv[RW]};
        den_q[j]   <= den_q[j-1];
        ok_q[j]    <= ok_q[j-1];
        side_q[j]  <= side_q[j-1];
        waddr_q[j] <= waddr_q[j-1];
      end
    end
  end

  // Frame bounds and store address.
  logic [DW-1:0] col, row;
  logic          keep;
  logic [AW-1:0] raddr;

  assign col   = quo_u_q[DW];
  assign row   = quo_v_q[DW];
  assign keep  = ok_q[DW]
              && (32'(col) < 32'(image_width_i)) && (int'(col) < MAX_WIDTH)
              && (32'(row) < 32'(image_height_i)) && (int'(row) < MAX_HEIGHT);
  assign raddr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);

  logic [AW-1:0]   addr_q;
  logic            hit_q;
  lpcc_pkg::side_t side_out_q;

  always_ff @(posedge clk_i) begin
    if (en_i[DW+1]) begin
      addr_q     <= side_q[DW].mode ? raddr : waddr_q[DW];
      hit_q      <= side_q[DW].mode ? keep : side_q[DW].wr_ok;
      side_out_q <= side_q[DW];
    end
  end

  assign addr_o = addr_q;
  assign hit_o  = hit_q;
  assign side_o = side_out_q;

endmodule

### src/lpcc_store.sv
// Frame store and output register: pixel writes and point color reads share
// one port, in item order. Uses lpcc_pkg.
module lpcc_store #(
  parameter int AW    = 22,
  parameter int DEPTH = 1 << AW
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [AW-1:0]   addr_i,
  input  logic            hit_i,
  input  lpcc_pkg::side_t side_i,
  output lpcc_pkg::out_t  out_o
);

  logic [23:0]    frame_mem [DEPTH];
  lpcc_pkg::out_t out_q;

  // A write item inside the store bounds stores its pixel; a kept point reads its color.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.world_x <= side_i.world_x;
      out_q.world_y <= side_i.world_y;
      out_q.world_z <= side_i.world_z;
      if (valid_i && hit_i) begin
        if (!side_i.mode) begin
          frame_mem[addr_i] <= side_i.wr_rgb;
        end else begin
          {out_q.color_red, out_q.color_green, out_q.color_blue} <= frame_mem[addr_i];
        end
      end
    end
  end

  assign out_o = out_q;

endmodule

### src/lidar_point_camera_colorizer_top.sv
// Top level of the lidar point colorizer: configuration registers, stage
// valid chain and the front, divider and store units. Uses lpcc_pkg.
//
// Usage: an input transfer on in_valid_i/in_stall_o carries either a pixel
// (mode 0) that is written to the frame store, or a lidar point (mode 1).
// A point in front of the camera that lands inside the configured frame
// produces one output transfer on out_valid_o/out_stall_i with its
// pose-transformed position and the color of the stored pixel; any other
// point and every pixel write produce nothing.
// The pipeline holds three projection stages, a range check, one divider
// stage per quotient bit (DW, the larger of clog2(MAX_WIDTH) and
// clog2(MAX_HEIGHT)), a bound stage and the store read. One item is
// accepted per cycle while in_stall_o is low. Each stage has its own
// valid bit and advances when it is empty or its successor advances, so
// a stalled output holds the last stage while earlier bubbles fill and
// new items keep entering until the pipe is full. Reset clears the valid
// bits and restores the identity pose and a 1920 x 1080 frame; the frame
// store has no reset and a pixel must be written before a point reads it.
// The user must write configuration only while idle; no logic enforces it.
module lidar_point_camera_colorizer_top #(
  parameter int MAX_WIDTH  = lpcc_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = lpcc_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lpcc_pkg::in_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lpcc_pkg::out_t                out_o,
  input  logic                          cfg_we_i,
  input  logic [lpcc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lpcc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int UW    = $clog2(MAX_WIDTH);
  localparam int VW    = $clog2(MAX_HEIGHT);
  localparam int DW    = (UW > VW) ? UW : VW;
  localparam int NSTG  = DW + 6;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // Configuration registers.
  logic [2:0][62:0] rot_q;
  logic [2:0][31:0] shift_q;
  logic [11:0]      width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= lpcc_pkg::RotRow0Rst;
      rot_q[1] <= lpcc_pkg::RotRow1Rst;
      rot_q[2] <= lpcc_pkg::RotRow2Rst;
      shift_q  <= '0;
      width_q  <= lpcc_pkg::WidthRst;
      height_q <= lpcc_pkg::HeightRst;
    end else if (cfg_we_i) begin
      case (lpcc_pkg::cfg_idx_e'(cfg_idx_i))
        lpcc_pkg::CFG_ROT_ROW0:     rot_q[0]   <= cfg_wdata_i;
        lpcc_pkg::CFG_ROT_ROW1:     rot_q[1]   <= cfg_wdata_i;
        lpcc_pkg::CFG_ROT_ROW2:     rot_q[2]   <= cfg_wdata_i;
        lpcc_pkg::CFG_SHIFT_X:      shift_q[0] <= cfg_wdata_i[31:0];
        lpcc_pkg::CFG_SHIFT_Y:      shift_q[1] <= cfg_wdata_i[31:0];
        lpcc_pkg::CFG_SHIFT_Z:      shift_q[2] <= cfg_wdata_i[31:0];
        lpcc_pkg::CFG_IMAGE_WIDTH:  width_q    <= cfg_wdata_i[11:0];
        lpcc_pkg::CFG_IMAGE_HEIGHT: height_q   <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic [NSTG:1] valid_q;
  logic [NSTG:1] stage_en;

  always_comb begin
    stage_en[NSTG] = !valid_q[NSTG] || !out_stall_i;
    for (int k = NSTG - 1; k >= 1; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign in_stall_o = !stage_en[1];

  // Units.
  logic signed [lpcc_pkg::NumW-1:0] nu, nv;
  logic [lpcc_pkg::CzW-1:0]         cz;
  logic                             drop;
  lpcc_pkg::side_t                  side_f, side_s;
  logic [AW-1:0]                    waddr, addr;
  logic                             hit;

  lpcc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_front (
    .clk_i  (clk_i),
    .en_i   (stage_en[3:1]),
    .in_i   (in_i),
    .rot_i  (rot_q),
    .shift_i(shift_q),
    .nu_o   (nu),
    .nv_o   (nv),
    .cz_o   (cz),
    .drop_o (drop),
    .side_o (side_f),
    .waddr_o(waddr)
  );

  lpcc_div #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW),
    .UW        (UW),
    .VW        (VW),
    .DW        (DW)
  ) u_div (
    .clk_i         (clk_i),
    .en_i          (stage_en[NSTG-1:4]),
    .nu_i          (nu),
    .nv_i          (nv),
    .cz_i          (cz),
    .drop_i        (drop),
    .side_i        (side_f),
    .waddr_i       (waddr),
    .image_width_i (width_q),
    .image_height_i(height_q),
    .addr_o        (addr),
    .hit_o         (hit),
    .side_o        (side_s)
  );

  lpcc_store #(
    .AW   (AW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (stage_en[NSTG]),
    .valid_i(valid_q[NSTG-1]),
    .addr_i (addr),
    .hit_i  (hit),
    .side_i (side_s),
    .out_o  (out_o)
  );

  // Valid chain; only kept points reach the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[1]) begin
        valid_q[1] <= in_valid_i;
      end
      for (int k = 2; k < NSTG; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
      if (stage_en[NSTG]) begin
        valid_q[NSTG] <= valid_q[NSTG-1] && hit && side_s.mode;
      end
    end
  end

  assign out_valid_o = valid_q[NSTG];

  // The input only stalls when the first stage holds an item.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> valid_q[1])
    else $error("input stalled with an empty first stage");

  // A held result freezes the last stage.
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NSTG] && out_stall_i) |-> !stage_en[NSTG])
    else $error("last stage enabled while its result is held");

  // An accepted input transfer occupies the first stage next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[1])
    else $error("accepted item missing from the first stage");

endmodule
